[design/pssg_pkg.sv]
// ============================================================================
// pssg_pkg
// Shared types and constants for the slot store and gather block.
// ============================================================================
package pssg_pkg;

    localparam int PARTITIONS   = 16;
    localparam int STORE_SLOTS  = 4096;
    localparam int VALUE_BITS   = 32;
    localparam int SUM_BITS     = VALUE_BITS + 12;
    localparam int PID_BITS     = 4;
    localparam int SLOT_BITS    = 12;
    localparam int CNT_BITS     = 13;
    localparam int COUNTER_MAX  = 8191;
    localparam int SRC_BITS     = 32;
    localparam int SCORE_BITS   = 32;
    localparam int DAMP_BITS    = 17;
    localparam int TELE_BITS    = 32;
    localparam int CFG_IDX_BITS = 4;
    localparam int CFG_DATA_BITS = 32;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_BITS    = 1;
    localparam int QCNT_BITS    = 2;

    // operation codes
    localparam logic [2:0] OP_CLEAR   = 3'd0;
    localparam logic [2:0] OP_LOAD    = 3'd1;
    localparam logic [2:0] OP_DEPOSIT = 3'd2;
    localparam logic [2:0] OP_GATHER  = 3'd3;
    localparam logic [2:0] OP_EMPTY   = 3'd4;

    // result kinds
    localparam logic RK_SCORE = 1'b0;
    localparam logic RK_ACK   = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_DAMPING  = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TELEPORT = 4'd1;

    typedef struct packed {
        logic [2:0]            operation;
        logic [PID_BITS-1:0]   partition_id;
        logic [SRC_BITS-1:0]   source_node;
        logic [VALUE_BITS-1:0] contribution;
        logic [SLOT_BITS-1:0]  slot_number;
        logic                  last_of_node;
    } in_item_t;

    typedef struct packed {
        logic                  result_kind;
        logic [SCORE_BITS-1:0] node_score;
        logic [SLOT_BITS-1:0]  written_slot;
        logic                  slot_overflow;
    } out_item_t;

    typedef enum logic [1:0] {
        BK_WRITE,
        BK_OVERFLOW,
        BK_GATHER,
        BK_EMPTY
    } back_kind_t;

    typedef struct packed {
        back_kind_t            kind;
        logic [SLOT_BITS-1:0]  slot;
        logic [VALUE_BITS-1:0] value;
        logic                  last;
    } back_cmd_t;

    typedef struct packed {
        logic      push;
        back_cmd_t cmd;
    } queue_wr_t;

    typedef struct packed {
        logic      avail;
        logic      full;
        back_cmd_t cmd;
    } queue_rd_t;

    typedef struct packed {
        logic [DAMP_BITS-1:0] damping_q16;
        logic [TELE_BITS-1:0] teleport_q32;
    } cfg_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_ACC,
        BS_MUL,
        BS_FIN
    } back_state_t;

endpackage

[design/pagerank_slot_store_and_gather_top.sv]
// ============================================================================
// pagerank_slot_store_and_gather_top
// Partitioned contribution store with deposit and gather for one rank step.
// ============================================================================
// Usage:
//   An item is taken at a clock edge with start high and busy low. Clear and
//   load items finish in the front end and give no result. Deposit, gather
//   and empty-node items go through a two-entry command queue to the back
//   end, which owns the 4096-slot store and the gather sum.
//   Each result shows on result for one cycle with result_valid high; the
//   receiver cannot stall, so results never back up into the block.
//   In the back end a deposit or empty node is done from the idle state; a
//   gather reads the store then adds, and the last gather of a node goes on
//   to a split multiply, then the teleport add and saturation. The back end
//   has a single store port and takes a new command only when idle, so a
//   gather holds back the queue until its steps are done; busy rises only
//   while the queue is full.
//   Configuration writes on cfg_valid/cfg_ready are taken every cycle; the
//   user must make them while the block is idle; no logic enforces that.
//   Reset clears counters, source marks, gather sum, queue and sequencer;
//   partition bases and store slots hold whatever they had until written.
// ============================================================================
module pagerank_slot_store_and_gather_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  pssg_pkg::in_item_t                    item,
    output logic                                  result_valid,
    output pssg_pkg::out_item_t                   result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pssg_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [pssg_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    logic                 accept;
    logic                 pop;
    pssg_pkg::queue_wr_t  qwr;
    pssg_pkg::queue_rd_t  qrd;
    pssg_pkg::cfg_t       cfg_reg;

    assign busy      = qrd.full;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.damping_q16  <= pssg_pkg::DAMP_BITS'(9830);
            cfg_reg.teleport_q32 <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pssg_pkg::CFG_DAMPING:
                    cfg_reg.damping_q16 <= cfg_data[pssg_pkg::DAMP_BITS-1:0];
                pssg_pkg::CFG_TELEPORT:
                    cfg_reg.teleport_q32 <= cfg_data[pssg_pkg::TELE_BITS-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    pssg_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .wr     (qwr)
    );

    pssg_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (qwr),
        .pop   (pop),
        .rd    (qrd)
    );

    pssg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rd           (qrd),
        .cfg          (cfg_reg),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

    // score results carry no slot and no overflow flag
    a_score_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.result_kind == pssg_pkg::RK_SCORE))
        |-> ((result.written_slot == '0) && !result.slot_overflow))
        else $error("score result with slot fields set");

    // acks carry no score, and an overflowed deposit reports slot zero
    a_ack_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.result_kind == pssg_pkg::RK_ACK))
        |-> ((result.node_score == '0)
             && (!result.slot_overflow || (result.written_slot == '0))))
        else $error("deposit ack with inconsistent fields");

    // busy only while queued commands wait
    a_busy_queue: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> qrd.avail)
        else $error("busy with empty command queue");

    // an item that needs no back-end work queues no command
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !qrd.avail && (item.operation != pssg_pkg::OP_DEPOSIT)
         && (item.operation != pssg_pkg::OP_GATHER)
         && (item.operation != pssg_pkg::OP_EMPTY))
        |=> !qrd.avail)
        else $error("command queued for an item that needs no back-end work");

endmodule

[design/pssg_front.sv]
// ============================================================================
// pssg_front
// Takes items, keeps partition counters, source marks and bases, and turns
// deposits, gathers and empty-node items into commands for the back end.
// ============================================================================
module pssg_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  pssg_pkg::in_item_t  item,
    output pssg_pkg::queue_wr_t wr
);

    localparam int TGT_BITS = pssg_pkg::CNT_BITS + 2;

    logic [pssg_pkg::CNT_BITS-1:0]  cnt_reg       [pssg_pkg::PARTITIONS];
    logic                           mark_valid_reg[pssg_pkg::PARTITIONS];
    logic [pssg_pkg::SRC_BITS-1:0]  mark_src_reg  [pssg_pkg::PARTITIONS];
    logic [pssg_pkg::SLOT_BITS-1:0] base_reg      [pssg_pkg::PARTITIONS];

    logic                           pid_ok;
    logic                           new_src;
    logic [pssg_pkg::CNT_BITS-1:0]  cnt_cur;
    logic [pssg_pkg::CNT_BITS-1:0]  cnt_new;
    logic signed [TGT_BITS-1:0]     target;
    logic                           in_store;

    // deposit slot from base and advanced counter
    always_comb
    begin
        pid_ok  = int'(item.partition_id) < pssg_pkg::PARTITIONS;
        cnt_cur = cnt_reg[item.partition_id];
        new_src = !mark_valid_reg[item.partition_id]
                  || (mark_src_reg[item.partition_id] != item.source_node);
        if (new_src && (int'(cnt_cur) < pssg_pkg::COUNTER_MAX))
            cnt_new = cnt_cur + pssg_pkg::CNT_BITS'(1);
        else
            cnt_new = cnt_cur;
        target   = $signed({3'b000, base_reg[item.partition_id]})
                 + $signed({2'b00, cnt_new})
                 - TGT_BITS'(1);
        in_store = (target >= TGT_BITS'(0)) && (target < TGT_BITS'(pssg_pkg::STORE_SLOTS));
    end

    // command to the back end
    always_comb
    begin
        wr.push      = 1'b0;
        wr.cmd.kind  = pssg_pkg::BK_GATHER;
        wr.cmd.slot  = item.slot_number;
        wr.cmd.value = item.contribution;
        wr.cmd.last  = item.last_of_node;
        case (item.operation)
            pssg_pkg::OP_DEPOSIT:
            begin
                wr.push     = accept;
                wr.cmd.kind = (pid_ok && in_store) ? pssg_pkg::BK_WRITE
                                                   : pssg_pkg::BK_OVERFLOW;
                wr.cmd.slot = target[pssg_pkg::SLOT_BITS-1:0];
            end
            pssg_pkg::OP_GATHER:
            begin
                wr.push     = accept;
                wr.cmd.kind = pssg_pkg::BK_GATHER;
            end
            pssg_pkg::OP_EMPTY:
            begin
                wr.push     = accept;
                wr.cmd.kind = pssg_pkg::BK_EMPTY;
            end
            default:
            begin
                wr.push = 1'b0;
            end
        endcase
    end

    // counters and source marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pssg_pkg::PARTITIONS; i++)
            begin
                cnt_reg[i]        <= '0;
                mark_valid_reg[i] <= 1'b0;
                mark_src_reg[i]   <= '0;
            end
        end
        else if (accept)
        begin
            if (item.operation == pssg_pkg::OP_CLEAR)
            begin
                for (int i = 0; i < pssg_pkg::PARTITIONS; i++)
                    cnt_reg[i] <= '0;
            end
            else if ((item.operation == pssg_pkg::OP_DEPOSIT) && pid_ok)
            begin
                cnt_reg[item.partition_id] <= cnt_new;
                if (new_src)
                begin
                    mark_valid_reg[item.partition_id] <= 1'b1;
                    mark_src_reg[item.partition_id]   <= item.source_node;
                end
            end
        end
    end

    // partition bases, undefined until loaded
    always_ff @(posedge clk)
    begin
        if (accept && (item.operation == pssg_pkg::OP_LOAD) && pid_ok)
            base_reg[item.partition_id] <= item.slot_number;
    end

endmodule

[design/pssg_queue.sv]
// ============================================================================
// pssg_queue
// Short command queue between the front and back ends.
// ============================================================================
module pssg_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  pssg_pkg::queue_wr_t wr,
    input  logic                pop,
    output pssg_pkg::queue_rd_t rd
);

    pssg_pkg::back_cmd_t             entry_reg [pssg_pkg::QUEUE_DEPTH];
    logic [pssg_pkg::QPTR_BITS-1:0]  wr_ptr_reg;
    logic [pssg_pkg::QPTR_BITS-1:0]  rd_ptr_reg;
    logic [pssg_pkg::QCNT_BITS-1:0]  count_reg;
    logic                            do_push;
    logic                            do_pop;

    // status and head entry
    always_comb
    begin
        rd.avail = count_reg != '0;
        rd.full  = count_reg == pssg_pkg::QCNT_BITS'(pssg_pkg::QUEUE_DEPTH);
        rd.cmd   = entry_reg[rd_ptr_reg];
        do_push  = wr.push && !rd.full;
        do_pop   = pop && rd.avail;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + pssg_pkg::QPTR_BITS'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + pssg_pkg::QPTR_BITS'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + pssg_pkg::QCNT_BITS'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - pssg_pkg::QCNT_BITS'(1);
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wr.cmd;
    end

endmodule

[design/pssg_back.sv]
// ============================================================================
// pssg_back
// Carries out queued commands: store writes, gathers with a saturating sum,
// and the damped score with teleport term.
// ============================================================================
module pssg_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pssg_pkg::queue_rd_t  rd,
    input  pssg_pkg::cfg_t       cfg,
    output logic                 pop,
    output logic                 result_valid,
    output pssg_pkg::out_item_t  result
);

    localparam int HI_BITS   = pssg_pkg::SUM_BITS - 16;
    localparam int HI_M_BITS = HI_BITS + pssg_pkg::DAMP_BITS;
    localparam int LO_M_BITS = 16 + pssg_pkg::DAMP_BITS;
    localparam int PROD_BITS = HI_M_BITS + 1;
    localparam logic [pssg_pkg::DAMP_BITS-1:0] ONE_Q16 = pssg_pkg::DAMP_BITS'(65536);
    localparam logic [PROD_BITS-1:0] SCORE_LIMIT =
        PROD_BITS'({pssg_pkg::SCORE_BITS{1'b1}});

    logic [pssg_pkg::VALUE_BITS-1:0] mem [pssg_pkg::STORE_SLOTS];
    logic [pssg_pkg::VALUE_BITS-1:0] rdata_reg;

    pssg_pkg::back_state_t         state_reg, state_next;
    logic [pssg_pkg::SUM_BITS-1:0] sum_reg, sum_next;
    logic                          last_reg, last_next;
    logic                          ok_reg, ok_next;
    logic [HI_M_BITS-1:0]          hi_m_reg, hi_m_next;
    logic [LO_M_BITS-1:0]          lo_m_reg, lo_m_next;
    logic                          res_valid_reg, res_valid_next;
    pssg_pkg::out_item_t           res_reg, res_next;

    logic                             mem_we;
    logic                             mem_re;
    logic [pssg_pkg::DAMP_BITS-1:0]   damp_clip;
    logic [pssg_pkg::DAMP_BITS-1:0]   mult;
    logic [pssg_pkg::VALUE_BITS-1:0]  add_val;
    logic [pssg_pkg::SUM_BITS:0]      sum_wide;
    logic [PROD_BITS-1:0]             prod;
    logic [pssg_pkg::SCORE_BITS:0]    score_wide;

    // multiplier is one minus the clipped damping
    always_comb
    begin
        damp_clip = (cfg.damping_q16 > ONE_Q16) ? ONE_Q16 : cfg.damping_q16;
        mult      = ONE_Q16 - damp_clip;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        last_next      = last_reg;
        ok_next        = ok_reg;
        hi_m_next      = hi_m_reg;
        lo_m_next      = lo_m_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        add_val        = ok_reg ? rdata_reg : '0;
        sum_wide       = {1'b0, sum_reg} + (pssg_pkg::SUM_BITS + 1)'(add_val);
        prod           = PROD_BITS'(hi_m_reg) + PROD_BITS'(lo_m_reg >> 16);
        score_wide     = {1'b0, prod[pssg_pkg::SCORE_BITS-1:0]}
                       + {1'b0, cfg.teleport_q32};

        unique case (state_reg)
            pssg_pkg::BS_IDLE:
            begin
                if (rd.avail)
                begin
                    pop = 1'b1;
                    res_next.result_kind   = pssg_pkg::RK_ACK;
                    res_next.node_score    = '0;
                    res_next.written_slot  = '0;
                    res_next.slot_overflow = 1'b0;
                    case (rd.cmd.kind)
                        pssg_pkg::BK_WRITE:
                        begin
                            mem_we                = 1'b1;
                            res_valid_next        = 1'b1;
                            res_next.written_slot = rd.cmd.slot;
                        end
                        pssg_pkg::BK_OVERFLOW:
                        begin
                            res_valid_next         = 1'b1;
                            res_next.slot_overflow = 1'b1;
                        end
                        pssg_pkg::BK_EMPTY:
                        begin
                            sum_next             = '0;
                            res_valid_next       = 1'b1;
                            res_next.result_kind = pssg_pkg::RK_SCORE;
                        end
                        default:
                        begin
                            mem_re     = 1'b1;
                            last_next  = rd.cmd.last;
                            ok_next    = int'(rd.cmd.slot) < pssg_pkg::STORE_SLOTS;
                            state_next = pssg_pkg::BS_ACC;
                        end
                    endcase
                end
            end
            pssg_pkg::BS_ACC:
            begin
                // saturating accumulate
                if (sum_wide[pssg_pkg::SUM_BITS])
                    sum_next = '1;
                else
                    sum_next = sum_wide[pssg_pkg::SUM_BITS-1:0];
                state_next = last_reg ? pssg_pkg::BS_MUL : pssg_pkg::BS_IDLE;
            end
            pssg_pkg::BS_MUL:
            begin
                // split product keeps each multiplier narrow
                hi_m_next  = HI_M_BITS'(sum_reg[pssg_pkg::SUM_BITS-1:16])
                           * HI_M_BITS'(mult);
                lo_m_next  = LO_M_BITS'(sum_reg[15:0]) * LO_M_BITS'(mult);
                sum_next   = '0;
                state_next = pssg_pkg::BS_FIN;
            end
            pssg_pkg::BS_FIN:
            begin
                res_valid_next         = 1'b1;
                res_next.result_kind   = pssg_pkg::RK_SCORE;
                res_next.written_slot  = '0;
                res_next.slot_overflow = 1'b0;
                if ((prod > SCORE_LIMIT) || score_wide[pssg_pkg::SCORE_BITS])
                    res_next.node_score = '1;
                else
                    res_next.node_score = score_wide[pssg_pkg::SCORE_BITS-1:0];
                state_next = pssg_pkg::BS_IDLE;
            end
            default:
            begin
                state_next = pssg_pkg::BS_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pssg_pkg::BS_IDLE;
            sum_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        ok_reg   <= ok_next;
        hi_m_reg <= hi_m_next;
        lo_m_reg <= lo_m_next;
        res_reg  <= res_next;
    end

    // contribution store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[rd.cmd.slot] <= rd.cmd.value;
        if (mem_re)
            rdata_reg <= mem[rd.cmd.slot];
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

[dv/tb_pagerank_slot_store_and_gather_top.sv]
// ============================================================================
// tb_pagerank_slot_store_and_gather_top
// Self-checking bench for the partitioned slot store and gather block. A
// tracking model of counters, source marks, bases, store and gather sum
// predicts every deposit ack and node score. Results are matched in order.
// Stimulus: directed corners, then random deposit and gather traffic under
// several register settings.
// ============================================================================
module tb_pagerank_slot_store_and_gather_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0]                     OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0]                     OP_SPARE_LAST  = 3'd7;
    localparam logic [pssg_pkg::DAMP_BITS-1:0] DAMP_RESET     = 17'd9830;
    localparam logic [pssg_pkg::DAMP_BITS-1:0] DAMP_ONE       = 17'd65536;
    localparam logic [pssg_pkg::SUM_BITS-1:0]  SUM_MAX        = '1;
    localparam logic [63:0]                    SCORE_MAX      = 64'hFFFF_FFFF;
    localparam int DRAIN_CYCLES  = 16;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_ROUNDS = 5;
    localparam int ROUND_ITEMS   = 350;

    // ------------------------------------------------------------------------
    // tracking model of the block and the results it still owes
    // ------------------------------------------------------------------------
    class rank_step_tracker;
        logic [pssg_pkg::DAMP_BITS-1:0]  damping;
        logic [pssg_pkg::TELE_BITS-1:0]  teleport;
        logic [pssg_pkg::CNT_BITS-1:0]   counters [pssg_pkg::PARTITIONS];
        bit                              mark_valid [pssg_pkg::PARTITIONS];
        logic [pssg_pkg::SRC_BITS-1:0]   mark_src [pssg_pkg::PARTITIONS];
        logic [pssg_pkg::SLOT_BITS-1:0]  bases [pssg_pkg::PARTITIONS];
        bit                              base_loaded [pssg_pkg::PARTITIONS];
        logic [pssg_pkg::VALUE_BITS-1:0] store [pssg_pkg::STORE_SLOTS];
        bit                              slot_written [pssg_pkg::STORE_SLOTS];
        int                              written_slots [$];
        logic [pssg_pkg::SUM_BITS-1:0]   sum;
        pssg_pkg::out_item_t             pending_results [$];
        int                              mismatches;

        function new();
            damping    = DAMP_RESET;
            teleport   = '0;
            sum        = '0;
            mismatches = 0;
            foreach (counters[i])
            begin
                counters[i]    = '0;
                mark_valid[i]  = 1'b0;
                mark_src[i]    = '0;
                bases[i]       = '0;
                base_loaded[i] = 1'b0;
            end
            foreach (store[i])
            begin
                store[i]        = '0;
                slot_written[i] = 1'b0;
            end
        endfunction

        function void set_config(logic [pssg_pkg::CFG_IDX_BITS-1:0] idx,
                                 logic [pssg_pkg::CFG_DATA_BITS-1:0] data);
            if (idx == pssg_pkg::CFG_DAMPING)
                damping = data[pssg_pkg::DAMP_BITS-1:0];
            else if (idx == pssg_pkg::CFG_TELEPORT)
                teleport = data[pssg_pkg::TELE_BITS-1:0];
        endfunction

        function void push_result(logic kind, logic [pssg_pkg::SCORE_BITS-1:0] score,
                                  logic [pssg_pkg::SLOT_BITS-1:0] slot, logic ovf);
            pssg_pkg::out_item_t r;
            r.result_kind   = kind;
            r.node_score    = score;
            r.written_slot  = slot;
            r.slot_overflow = ovf;
            pending_results.insert(pending_results.size(), r);
        endfunction

        // sum * (1 - damping) truncated, plus teleport, saturated to 32 bits
        function logic [pssg_pkg::SCORE_BITS-1:0] score_of_sum();
            logic [63:0] mult;
            logic [63:0] prod;
            mult = (damping > DAMP_ONE) ? 64'd0 : 64'(DAMP_ONE - damping);
            prod = (64'(sum) * mult) >> 16;
            if (prod > SCORE_MAX)
                return '1;
            prod = prod + 64'(teleport);
            return (prod > SCORE_MAX) ? '1 : prod[pssg_pkg::SCORE_BITS-1:0];
        endfunction

        // advance the model by one accepted item
        function void note_item(pssg_pkg::in_item_t it);
            int p;
            int target;
            logic [pssg_pkg::SUM_BITS-1:0] add;
            p = int'(it.partition_id);
            case (it.operation)
                pssg_pkg::OP_CLEAR:
                begin
                    foreach (counters[i])
                        counters[i] = '0;
                end
                pssg_pkg::OP_LOAD:
                begin
                    bases[p]       = it.slot_number;
                    base_loaded[p] = 1'b1;
                end
                pssg_pkg::OP_DEPOSIT:
                begin
                    // a new source opens the next slot of the region
                    if (!mark_valid[p] || mark_src[p] != it.source_node)
                    begin
                        if (counters[p] < pssg_pkg::COUNTER_MAX)
                            counters[p] = counters[p] + 1'b1;
                        mark_valid[p] = 1'b1;
                        mark_src[p]   = it.source_node;
                    end
                    target = int'(bases[p]) + int'(counters[p]) - 1;
                    if (target < 0 || target >= pssg_pkg::STORE_SLOTS)
                        push_result(pssg_pkg::RK_ACK, '0, '0, 1'b1);
                    else
                    begin
                        store[target] = it.contribution;
                        if (!slot_written[target])
                        begin
                            slot_written[target] = 1'b1;
                            written_slots.insert(written_slots.size(), target);
                        end
                        push_result(pssg_pkg::RK_ACK, '0, pssg_pkg::SLOT_BITS'(target), 1'b0);
                    end
                end
                pssg_pkg::OP_GATHER:
                begin
                    add = pssg_pkg::SUM_BITS'(store[it.slot_number]);
                    sum = (SUM_MAX - sum < add) ? SUM_MAX : sum + add;
                    if (it.last_of_node)
                    begin
                        push_result(pssg_pkg::RK_SCORE, score_of_sum(), '0, 1'b0);
                        sum = '0;
                    end
                end
                pssg_pkg::OP_EMPTY:
                begin
                    sum = '0;
                    push_result(pssg_pkg::RK_SCORE, '0, '0, 1'b0);
                end
                default:
                begin
                end
            endcase
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        // match one strobed result against the oldest prediction
        function void check_result(pssg_pkg::out_item_t got);
            pssg_pkg::out_item_t want;
            if (pending_results.size() == 0)
            begin
                $error("result with nothing pending: kind %0d score 0x%0h slot %0d ovf %0d",
                       got.result_kind, got.node_score, got.written_slot, got.slot_overflow);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("result_kind", 64'(want.result_kind), 64'(got.result_kind));
            compare_field("node_score", 64'(want.node_score), 64'(got.node_score));
            compare_field("written_slot", 64'(want.written_slot), 64'(got.written_slot));
            compare_field("slot_overflow", 64'(want.slot_overflow), 64'(got.slot_overflow));
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    pssg_pkg::in_item_t                 item;
    logic                               result_valid;
    pssg_pkg::out_item_t                result;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [pssg_pkg::CFG_IDX_BITS-1:0]  cfg_index;
    logic [pssg_pkg::CFG_DATA_BITS-1:0] cfg_data;

    rank_step_tracker tracker;

    pagerank_slot_store_and_gather_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result monitor, values sampled as they stood before the edge
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            tracker.check_result(result);
    end

    // watchdog
    initial
    begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // item helpers
    // ------------------------------------------------------------------------
    function automatic pssg_pkg::in_item_t make_item(logic [2:0] op, int pid,
                                                     logic [pssg_pkg::SRC_BITS-1:0] src,
                                                     logic [pssg_pkg::VALUE_BITS-1:0] val,
                                                     int slot, bit last);
        pssg_pkg::in_item_t it;
        it.operation    = op;
        it.partition_id = pssg_pkg::PID_BITS'(pid);
        it.source_node  = src;
        it.contribution = val;
        it.slot_number  = pssg_pkg::SLOT_BITS'(slot);
        it.last_of_node = last;
        return it;
    endfunction

    function automatic pssg_pkg::in_item_t random_item();
        pssg_pkg::in_item_t it;
        it.operation    = 3'($urandom);
        it.partition_id = pssg_pkg::PID_BITS'($urandom);
        it.source_node  = $urandom;
        it.contribution = $urandom;
        it.slot_number  = pssg_pkg::SLOT_BITS'($urandom);
        it.last_of_node = 1'($urandom);
        return it;
    endfunction

    // gathers only touch slots that a deposit has filled
    function automatic pssg_pkg::in_item_t gather_item(bit last);
        pssg_pkg::in_item_t it;
        it = random_item();
        it.operation    = pssg_pkg::OP_GATHER;
        it.slot_number  = pssg_pkg::SLOT_BITS'(
            tracker.written_slots[$urandom_range(tracker.written_slots.size() - 1)]);
        it.last_of_node = last;
        return it;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap(bit burst);
        int r;
        r = $urandom_range(99);
        if (burst || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(30, 4);
    endfunction

    // ------------------------------------------------------------------------
    // driver tasks; each returns at the edge that took its item
    // ------------------------------------------------------------------------
    task automatic send_item(pssg_pkg::in_item_t it, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tracker.note_item(it);
    endtask

    // stop sending and let the block run dry
    task automatic settle_block();
        start <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [pssg_pkg::CFG_IDX_BITS-1:0] idx,
                             logic [pssg_pkg::CFG_DATA_BITS-1:0] data);
        settle_block();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tracker.set_config(idx, data);
    endtask

    // ------------------------------------------------------------------------
    // stimulus phases
    // ------------------------------------------------------------------------
    task automatic run_directed();
        // bases at the bottom, the top and near the top of the store
        send_item(make_item(pssg_pkg::OP_LOAD, 0, 0, 0, 0, 0), 0);
        send_item(make_item(pssg_pkg::OP_LOAD, 1, 0, 0, 4095, 0), 0);
        send_item(make_item(pssg_pkg::OP_LOAD, 2, 0, 0, 4000, 0), 0);
        // source id zero is new after reset, a repeat reuses the slot
        send_item(make_item(pssg_pkg::OP_DEPOSIT, 0, 32'h0, 32'hFFFF_FFFF, 0, 0), 0);
        send_item(make_item(pssg_pkg::OP_DEPOSIT, 0, 32'h0, 32'h1234_5678, 0, 1), 0);
        send_item(make_item(pssg_pkg::OP_DEPOSIT, 0, 32'hFFFF_FFFF, 32'h0, 4095, 0), 0);
        // top slot taken, next one falls past the store
        send_item(make_item(pssg_pkg::OP_DEPOSIT, 1, 32'd5, 32'h8000_0000, 0, 0), 0);
        send_item(make_item(pssg_pkg::OP_DEPOSIT, 1, 32'd6, 32'h0000_0001, 0, 0), 0);
        send_item(make_item(pssg_pkg::OP_DEPOSIT, 2, 32'd7, 32'hA5A5_A5A5, 0, 0), 0);
        // clear keeps marks: same source lands one below the base
        send_item(make_item(pssg_pkg::OP_CLEAR, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4095, 1), 0);
        send_item(make_item(pssg_pkg::OP_DEPOSIT, 0, 32'hFFFF_FFFF, 32'h5555_5555, 0, 0), 0);
        send_item(make_item(pssg_pkg::OP_DEPOSIT, 0, 32'd9, 32'hFFFF_FFFF, 0, 0), 0);
        // two-slot node at reset settings
        send_item(make_item(pssg_pkg::OP_GATHER, 0, 0, 0, 0, 0), 0);
        send_item(make_item(pssg_pkg::OP_GATHER, 0, 0, 0, 4095, 1), 0);
        // empty node drops a partial sum
        send_item(make_item(pssg_pkg::OP_GATHER, 0, 0, 0, 4000, 0), 0);
        send_item(make_item(pssg_pkg::OP_EMPTY, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4095, 1), 0);
        send_item(make_item(pssg_pkg::OP_GATHER, 0, 0, 0, 1, 1), 0);
        // spare operation codes do nothing
        for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
            send_item(make_item(3'(op), 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4095, 1), 0);
        // no damping with the top teleport term saturates
        write_reg(pssg_pkg::CFG_DAMPING, 32'd0);
        write_reg(pssg_pkg::CFG_TELEPORT, 32'hFFFF_FFFF);
        send_item(make_item(pssg_pkg::OP_GATHER, 0, 0, 0, 0, 0), 0);
        send_item(make_item(pssg_pkg::OP_GATHER, 0, 0, 0, 4095, 1), 0);
        // full damping leaves only the teleport term
        write_reg(pssg_pkg::CFG_DAMPING, 32'(DAMP_ONE));
        write_reg(pssg_pkg::CFG_TELEPORT, 32'h0000_1234);
        send_item(make_item(pssg_pkg::OP_GATHER, 0, 0, 0, 4000, 1), 0);
        // damping above one acts as one
        write_reg(pssg_pkg::CFG_DAMPING, 32'h0001_FFFF);
        send_item(make_item(pssg_pkg::OP_GATHER, 0, 0, 0, 0, 1), 0);
    endtask

    task automatic run_random_round(int count);
        pssg_pkg::in_item_t it;
        int sent;
        int len;
        int p;
        int r;
        bit burst;
        bit paused;
        sent   = 0;
        burst  = 1'b0;
        paused = 1'b0;
        while (sent < count)
        begin
            // stretches with no idling come and go
            if ($urandom_range(19) == 0)
                burst = !burst;
            // hold off once until every result is back
            if (!paused && sent >= count / 2)
            begin
                settle_block();
                paused = 1'b1;
            end
            r  = $urandom_range(99);
            it = random_item();
            if (r < 40)
            begin
                // deposit into a loaded region, often from the same source
                p = $urandom_range(pssg_pkg::PARTITIONS - 1);
                while (!tracker.base_loaded[p])
                    p = $urandom_range(pssg_pkg::PARTITIONS - 1);
                it.operation    = pssg_pkg::OP_DEPOSIT;
                it.partition_id = pssg_pkg::PID_BITS'(p);
                if (tracker.mark_valid[p] && $urandom_range(2) == 0)
                    it.source_node = tracker.mark_src[p];
            end
            else if (r < 75)
            begin
                // one node of one to four gathers
                len = $urandom_range(4, 1);
                repeat (len - 1)
                begin
                    send_item(gather_item(1'b0), pick_gap(burst));
                    sent++;
                end
                it = gather_item(1'b1);
            end
            else if (r < 78)
                it.operation = pssg_pkg::OP_CLEAR;
            else if (r < 85)
                it.operation = pssg_pkg::OP_LOAD;
            else if (r < 91)
                it.operation = pssg_pkg::OP_EMPTY;
            else if (r < 96)
                it.operation = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
            else
                it = gather_item(1'b0);
            send_item(it, pick_gap(burst));
            sent++;
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        tracker   = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        for (int round = 0; round < RANDOM_ROUNDS; round++)
        begin
            write_reg(pssg_pkg::CFG_DAMPING, (round % 2 == 1) ? $urandom_range(65536)
                                                              : $urandom_range(131071));
            write_reg(pssg_pkg::CFG_TELEPORT,
                      (round == 1) ? $urandom : $urandom_range(32'h00FF_FFFF));
            run_random_round(ROUND_ITEMS);
        end
        settle_block();

        if (tracker.pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", tracker.pending_results.size());
            tracker.mismatches++;
        end
        if (tracker.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
